/* design/learned_code_remap_table_unit_macros.svh */
// ----------------------------------------------------------------------------
// learned_code_remap_table_unit_macros.svh
// Assertion shorthands for the learned code remap table.
// ----------------------------------------------------------------------------
`ifndef LEARNED_CODE_REMAP_TABLE_UNIT_MACROS_SVH
`define LEARNED_CODE_REMAP_TABLE_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define LCRT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define LCRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lcrt_pkg.sv */
// ----------------------------------------------------------------------------
// lcrt_pkg
// Types and constants of the learned code remap table.
// ----------------------------------------------------------------------------
package lcrt_pkg;

    localparam int CODE_W   = 16;
    localparam int SLOT_W   = 8;
    localparam int KEY_W    = 7;
    localparam int STATUS_W = 3;

    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Erased table entry
    localparam code_t ERASED_CODE = 16'hFFFF;

    // Input opcodes
    localparam logic OP_CODE  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // Result kinds
    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    // Store status codes
    localparam status_t ST_STORED    = 3'd0;
    localparam status_t ST_SAME      = 3'd1;
    localparam status_t ST_DUPLICATE = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_IDLE      = 3'd4;

endpackage

/* design/learned_code_remap_table_unit.sv */
// ----------------------------------------------------------------------------
// learned_code_remap_table_unit
// Remote command code to key slot translation with a learned code table.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): opcode, command_code, slot_index. A code
// transaction latches the code and marks it pending; outside learning mode it
// is translated into the first table slot that holds it (0 when none does).
// A store transaction in learning mode with a code pending stores the latched
// code into the slot or reports same key, duplicate or map full.
// Output channel (out_valid/out_ready): result_kind, key_slot, store_status,
// stored_code; one result per transaction, none for a code taken in learning
// mode. Config: cfg_we/cfg_wdata write learning_mode at once.
// Timing: the table sits in one synchronous single-port memory and is scanned
// one entry per cycle. A lookup passes S_SCAN and S_EMIT, a store that scans
// S_SLOT, S_SCAN and S_EMIT; an idle or map full reply goes straight to
// S_EMIT, a same key reply via S_SLOT; a code in learning mode is only latched.
// One transaction is in work at a time; in_ready is high while the sequencer
// is idle, also while a result waits in the output register. A stalled
// receiver holds the next result in the sequencer until the output register
// frees. Reset: the table reads as erased (all ones) through per-entry valid
// flags; no clearing pass is needed, the block is ready right after reset.
// ----------------------------------------------------------------------------
`include "learned_code_remap_table_unit_macros.svh"

module learned_code_remap_table_unit #(
    parameter int SLOT_COUNT = 83
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            opcode,
    input  lcrt_pkg::code_t command_code,
    input  lcrt_pkg::slot_t slot_index,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            result_kind,
    output lcrt_pkg::key_t  key_slot,
    output lcrt_pkg::status_t store_status,
    output lcrt_pkg::code_t stored_code
);
    import lcrt_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(SLOT_COUNT);
    localparam logic [SLOT_W:0]   SLOT_LIMIT = (SLOT_W + 1)'(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SLOT,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t           state_reg;
    logic             learning_mode_reg;
    code_t            latched_code_reg;
    logic             code_pending_reg;
    code_t            key_reg;
    logic             kind_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             rd_pend_reg;
    key_t             res_key_reg;
    status_t          res_status_reg;
    code_t            res_stored_reg;
    logic             out_valid_reg;
    logic             out_kind_reg;
    key_t             out_key_reg;
    status_t          out_status_reg;
    code_t            out_stored_reg;
    logic [SLOT_COUNT-1:0] vld_reg;

    // Table memory and its registered read data
    code_t            mem [SLOT_COUNT];
    code_t            rd_data_reg;
    logic             rd_vld_reg;

    logic             in_fire;
    logic             store_ok;
    logic             slot_in_range;
    logic             scan_in_range;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    code_t            entry_code;
    logic             entry_hit;
    logic             scan_miss;
    logic             mem_we;
    logic             out_free;

    assign in_ready      = (state_reg == S_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign store_ok      = learning_mode_reg && code_pending_reg;
    assign slot_in_range = ({1'b0, slot_index} < SLOT_LIMIT);
    assign scan_in_range = (scan_cnt_reg < CNT_LIMIT);
    assign out_free      = !out_valid_reg || out_ready;

    // Select the read port: the named slot at accept, else the scan pointer
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = scan_cnt_reg[IDX_W-1:0];
        if (state_reg == S_IDLE)
        begin
            rd_addr = slot_index[IDX_W-1:0];
            rd_en   = in_fire && (opcode == OP_STORE) && store_ok && slot_in_range;
        end
        else if (state_reg == S_SCAN)
        begin
            rd_en = scan_in_range;
        end
    end

    // Compare the entry read last cycle; a never written entry reads erased
    assign entry_code = rd_vld_reg ? rd_data_reg : ERASED_CODE;
    assign entry_hit  = rd_pend_reg && (entry_code == key_reg);
    assign scan_miss  = rd_pend_reg && !entry_hit && (cmp_idx_reg == LAST_IDX);
    assign mem_we     = (state_reg == S_SCAN) && scan_miss && (kind_reg == KIND_STORE);

    // Write and read the table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    // Sequencer, latched code, valid flags and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            learning_mode_reg <= 1'b0;
            latched_code_reg  <= '0;
            code_pending_reg  <= 1'b0;
            key_reg           <= '0;
            kind_reg          <= KIND_KEY;
            slot_reg          <= '0;
            scan_cnt_reg      <= '0;
            cmp_idx_reg       <= '0;
            rd_pend_reg       <= 1'b0;
            res_key_reg       <= '0;
            res_status_reg    <= ST_IDLE;
            res_stored_reg    <= '0;
            out_valid_reg     <= 1'b0;
            out_kind_reg      <= KIND_KEY;
            out_key_reg       <= '0;
            out_status_reg    <= ST_IDLE;
            out_stored_reg    <= '0;
            vld_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                learning_mode_reg <= cfg_wdata;
            end

            // Drop a delivered result unless the sequencer refills the register
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    scan_cnt_reg <= '0;
                    rd_pend_reg  <= 1'b0;
                    if (in_fire)
                    begin
                        if (opcode == OP_CODE)
                        begin
                            latched_code_reg <= command_code;
                            code_pending_reg <= 1'b1;
                            key_reg          <= command_code;
                            kind_reg         <= KIND_KEY;
                            if (!learning_mode_reg)
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        else
                        begin
                            kind_reg       <= KIND_STORE;
                            key_reg        <= latched_code_reg;
                            slot_reg       <= slot_index[IDX_W-1:0];
                            res_key_reg    <= '0;
                            res_stored_reg <= '0;
                            if (!store_ok)
                            begin
                                res_status_reg <= ST_IDLE;
                                state_reg      <= S_EMIT;
                            end
                            else if (!slot_in_range)
                            begin
                                code_pending_reg <= 1'b0;
                                res_status_reg   <= ST_FULL;
                                state_reg        <= S_EMIT;
                            end
                            else
                            begin
                                code_pending_reg <= 1'b0;
                                state_reg        <= S_SLOT;
                            end
                        end
                    end
                end

                S_SLOT:
                begin
                    // Named slot already holds the code, else scan for a duplicate
                    if (entry_code == key_reg)
                    begin
                        res_status_reg <= ST_SAME;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    if (entry_hit)
                    begin
                        rd_pend_reg <= 1'b0;
                        if (kind_reg == KIND_KEY)
                        begin
                            res_key_reg    <= KEY_W'(cmp_idx_reg);
                            res_status_reg <= ST_IDLE;
                        end
                        else
                        begin
                            res_key_reg    <= '0;
                            res_status_reg <= ST_DUPLICATE;
                        end
                        res_stored_reg <= '0;
                        state_reg      <= S_EMIT;
                    end
                    else if (scan_miss)
                    begin
                        rd_pend_reg <= 1'b0;
                        res_key_reg <= '0;
                        if (kind_reg == KIND_KEY)
                        begin
                            res_status_reg <= ST_IDLE;
                            res_stored_reg <= '0;
                        end
                        else
                        begin
                            vld_reg[slot_reg] <= 1'b1;
                            res_status_reg    <= ST_STORED;
                            res_stored_reg    <= key_reg;
                        end
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        // Advance the scan one entry per cycle
                        rd_pend_reg <= scan_in_range;
                        cmp_idx_reg <= scan_cnt_reg[IDX_W-1:0];
                        if (scan_in_range)
                        begin
                            scan_cnt_reg <= scan_cnt_reg + 1'b1;
                        end
                    end
                end

                S_EMIT:
                begin
                    // Hold the result until the output register frees
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= kind_reg;
                        out_key_reg    <= res_key_reg;
                        out_status_reg <= res_status_reg;
                        out_stored_reg <= res_stored_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign key_slot     = out_key_reg;
    assign store_status = out_status_reg;
    assign stored_code  = out_stored_reg;

    // Checks
    `LCRT_ASSERT_SAME(a_key_result_clean,
        out_valid && (result_kind == KIND_KEY),
        (store_status == ST_IDLE) && (stored_code == '0),
        "translated key result carries store fields")
    `LCRT_ASSERT_SAME(a_write_in_range,
        mem_we,
        ({1'b0, slot_reg} < (IDX_W + 1)'(SLOT_COUNT)) && (kind_reg == KIND_STORE),
        "table write outside a store or beyond the slot count")
    `LCRT_ASSERT_NEXT(a_store_clears_pending,
        in_fire && (opcode == OP_STORE) && learning_mode_reg && code_pending_reg,
        !code_pending_reg,
        "store request in learning mode left the code pending")

endmodule
